>>> sv/cbg_pkg.sv
package cbg_pkg;

	// Fraction bits of the normalised intermediate values
	localparam int FRAC_BITS = 12;
	// Width of the signed tone result y (Q.FRAC_BITS)
	localparam int Y_W = 22;
	// Register stages in the whole datapath and in the divider tail
	localparam int PIPE_DEPTH = 12;
	localparam int DIV_STAGES = 4;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_CONTRAST   = 3'd0,
		REG_BRIGHTNESS = 3'd1,
		REG_GAMMA      = 3'd2,
		REG_COLOR_MODE = 3'd3,
		REG_LUMA_ONLY  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] blue_in;
		logic [7:0] green_in;
		logic [7:0] red_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] blue_out;
		logic [7:0] green_out;
		logic [7:0] red_out;
	} pix_out_t;

	typedef logic [15:0] log_tbl_t [256];

	// -log2(c/255) in Q.FRAC_BITS, piecewise linear; entry 0 unused (zero input)
	function automatic log_tbl_t build_log_tbl();
		log_tbl_t tbl;
		int x;
		int p;
		int frac;
		for (int c = 0; c < 256; c++) begin
			x = (c * (1 << FRAC_BITS) * 2 + 255) / 510;
			p = 0;
			for (int b = 0; b < 31; b++) begin
				if ((x >> b) != 0)
					p = b;
			end
			if (x == 0) begin
				tbl[c] = 16'd0;
			end else begin
				frac = ((x - (1 << p)) << FRAC_BITS) >> p;
				tbl[c] = 16'((FRAC_BITS - p) * (1 << FRAC_BITS) - frac);
			end
		end
		return tbl;
	endfunction

	localparam log_tbl_t LOG_TBL = build_log_tbl();

	// One restoring division step: {quotient bit, new remainder}
	function automatic logic [8:0] div_step(logic [7:0] rem, logic nb, logic [7:0] d);
		logic [8:0] r9;
		logic [8:0] res;
		r9 = {rem, nb};
		if (r9 >= {1'b0, d})
			res = {1'b1, 8'(r9 - {1'b0, d})};
		else
			res = {1'b0, r9[7:0]};
		return res;
	endfunction

endpackage

>>> sv/cbg_div_lane.sv
module cbg_div_lane import cbg_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] adv,
	input  logic [15:0]           dividend,
	input  logic [7:0]            divisor,
	output logic [7:0]            quotient
);

	// Quotient known to fit 8 bits; two bits resolved per stage
	logic [7:0] rem_q [DIV_STAGES];
	logic [7:0] low_q [DIV_STAGES];
	logic [7:0] quo_q [DIV_STAGES];
	logic [7:0] dv_q  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [7:0] rin, lin, qin, din, qn;
		logic [8:0] sa, sb;

		if (k == 0) begin : g_first
			assign rin = dividend[15:8];
			assign lin = dividend[7:0];
			assign qin = '0;
			assign din = divisor;
		end else begin : g_next
			assign rin = rem_q[k-1];
			assign lin = low_q[k-1];
			assign qin = quo_q[k-1];
			assign din = dv_q[k-1];
		end

		always_comb begin
			sa = div_step(rin, lin[7-2*k], din);
			sb = div_step(sa[7:0], lin[6-2*k], din);
			qn = qin;
			qn[7-2*k] = sa[8];
			qn[6-2*k] = sb[8];
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_q[k] <= sb[7:0];
				low_q[k] <= lin;
				quo_q[k] <= qn;
				dv_q[k]  <= din;
			end
		end
	end

	assign quotient = quo_q[DIV_STAGES-1];

endmodule

>>> sv/contrast_brightness_gamma_pixel.sv
// Throughput: one pixel per clock while not stalled; log table, gamma multiply,
// contrast multiply and a 4-stage restoring divider for the luma ratio are all
// fully pipelined. Back-pressure collapses bubbles stage by stage.
// Reset (arst_n low, asynchronous): pipeline emptied, registers to contrast 1.0,
// brightness 0, gamma 1.0, colour mode and luma-only set.
module contrast_brightness_gamma_pixel import cbg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  pix_in_t     src_data,
	output logic        dst_valid,
	input  logic        dst_ready,
	output pix_out_t    dst_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic            vzero;
		logic [2:0]      neg;
		logic [2:0]      ovf;
	} side_t;

	// Configuration registers
	logic signed [15:0] contrast_q;
	logic signed [15:0] brightness_q;
	logic [15:0]        gamma_q;
	logic               color_q;
	logic               luma_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q   <= 16'sd256;
			brightness_q <= '0;
			gamma_q      <= 16'd4096;
			color_q      <= 1'b1;
			luma_q       <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CONTRAST:   contrast_q   <= cfg_data;
				REG_BRIGHTNESS: brightness_q <= cfg_data;
				REG_GAMMA:      gamma_q      <= cfg_data;
				REG_COLOR_MODE: color_q      <= cfg_data[0];
				REG_LUMA_ONLY:  luma_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Valid bits and per-stage advance
	logic [PIPE_DEPTH:1]   vld_q;
	logic [PIPE_DEPTH+1:1] adv;

	always_comb begin
		adv[PIPE_DEPTH+1] = dst_ready;
		for (int k = PIPE_DEPTH; k >= 1; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1])
				vld_q[1] <= src_valid;
			for (int k = 2; k <= PIPE_DEPTH; k++) begin
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign src_ready = adv[1];
	assign dst_valid = vld_q[PIPE_DEPTH];

	// s1: value channel and lane operands
	logic [7:0] vmax;
	logic [7:0] ch_s1 [3];
	logic [7:0] op_s1 [3];
	logic [7:0] v_s1;

	always_comb begin
		vmax = src_data.blue_in;
		if (src_data.green_in > vmax)
			vmax = src_data.green_in;
		if (src_data.red_in > vmax)
			vmax = src_data.red_in;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ch_s1[0] <= src_data.blue_in;
			ch_s1[1] <= src_data.green_in;
			ch_s1[2] <= src_data.red_in;
			op_s1[0] <= (color_q && luma_q) ? vmax : src_data.blue_in;
			op_s1[1] <= src_data.green_in;
			op_s1[2] <= src_data.red_in;
			v_s1     <= vmax;
		end
	end

	// s2: log magnitude lookup
	logic [15:0] m_s2 [3];
	logic [2:0]  zero_s2;
	logic [7:0]  ch_s2 [3];
	logic [7:0]  v_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int l = 0; l < 3; l++) begin
				m_s2[l]    <= LOG_TBL[op_s1[l]];
				zero_s2[l] <= (op_s1[l] == 8'd0);
				ch_s2[l]   <= ch_s1[l];
			end
			v_s2 <= v_s1;
		end
	end

	// s3: exponent = log magnitude * gamma, rounded
	logic [32:0] eprod [3];
	logic [19:0] e_s3 [3];
	logic [2:0]  zero_s3;
	logic [7:0]  ch_s3 [3];
	logic [7:0]  v_s3;

	always_comb begin
		for (int l = 0; l < 3; l++)
			eprod[l] = 33'(m_s2[l] * gamma_q) + 33'd2048;
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int l = 0; l < 3; l++) begin
				e_s3[l]  <= eprod[l][31:12];
				ch_s3[l] <= ch_s2[l];
			end
			zero_s3 <= zero_s2;
			v_s3    <= v_s2;
		end
	end

	// s4: exp2 of the negated exponent
	logic [13:0] pbase [3];
	logic [13:0] pshift [3];
	logic [12:0] pw_c [3];
	logic [12:0] pw_s4 [3];
	logic [7:0]  ch_s4 [3];
	logic [7:0]  v_s4;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			pbase[l]  = 14'd8192 - {2'b00, e_s3[l][11:0]};
			pshift[l] = pbase[l] >> ({1'b0, e_s3[l][15:12]} + 5'd1);
			if (zero_s3[l])
				pw_c[l] = (gamma_q == 16'd0) ? 13'd4096 : 13'd0;
			else if (e_s3[l][19:12] > 8'd12)
				pw_c[l] = '0;
			else
				pw_c[l] = pshift[l][12:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int l = 0; l < 3; l++) begin
				pw_s4[l] <= pw_c[l];
				ch_s4[l] <= ch_s3[l];
			end
			v_s4 <= v_s3;
		end
	end

	// s5: contrast gain and brightness offset
	logic signed [30:0]    cprod [3];
	logic signed [30:0]    crnd [3];
	logic signed [Y_W-1:0] y_s5 [3];
	logic [7:0]            ch_s5 [3];
	logic [7:0]            v_s5;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			cprod[l] = 31'(contrast_q) * 31'($signed({2'b00, pw_s4[l]}));
			crnd[l]  = cprod[l] + 31'sd128;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int l = 0; l < 3; l++) begin
				y_s5[l]  <= Y_W'(crnd[l] >>> 8) + Y_W'(brightness_q);
				ch_s5[l] <= ch_s4[l];
			end
			v_s5 <= v_s4;
		end
	end

	// s6: direct byte conversion and luma numerator product
	logic signed [30:0] z6 [3];
	logic signed [30:0] r6 [3];
	logic [7:0]         byte_c [3];
	logic signed [30:0] t_c [3];
	logic [7:0]         byte_s6 [3];
	logic signed [30:0] t_s6 [3];
	logic [7:0]         v_s6;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			z6[l] = 31'(y_s5[l]) * 31'sd255 + 31'sd2048;
			r6[l] = z6[l] >>> 12;
			if (r6[l] < 0)
				byte_c[l] = 8'd0;
			else if (r6[l] > 31'sd255)
				byte_c[l] = 8'd255;
			else
				byte_c[l] = r6[l][7:0];
			t_c[l] = 31'($signed({1'b0, ch_s5[l]})) * 31'(y_s5[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int l = 0; l < 3; l++) begin
				byte_s6[l] <= byte_c[l];
				t_s6[l]    <= t_c[l];
			end
			v_s6 <= v_s5;
		end
	end

	// s7: rounded numerator scaled down by 2^13, saturation flags
	logic signed [41:0] n7 [3];
	logic [15:0]        mlo_s7 [3];
	logic [7:0]         v_s7;
	side_t              side_c, side_s7;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			n7[l] = (42'(t_s6[l]) <<< 9) - (42'(t_s6[l]) <<< 1)
				+ $signed({22'd0, v_s6, 12'd0});
			side_c.bytes[l] = byte_s6[l];
			side_c.neg[l]   = n7[l][41];
			side_c.ovf[l]   = !n7[l][41] && (n7[l][40:21] >= 20'(v_s6));
		end
		side_c.vzero = (v_s6 == 8'd0);
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			for (int l = 0; l < 3; l++)
				mlo_s7[l] <= n7[l][28:13];
			v_s7    <= v_s6;
			side_s7 <= side_c;
		end
	end

	// s8..s11: quotient of the luma ratio, one divider per channel
	logic [7:0] quo [3];

	for (genvar l = 0; l < 3; l++) begin : g_div
		cbg_div_lane u_div (
			.clk      (clk),
			.adv      (adv[11:8]),
			.dividend (mlo_s7[l]),
			.divisor  (v_s7),
			.quotient (quo[l])
		);
	end

	side_t side_s8, side_s9, side_s10, side_s11;

	always_ff @(posedge clk) begin
		if (adv[8])
			side_s8 <= side_s7;
		if (adv[9])
			side_s9 <= side_s8;
		if (adv[10])
			side_s10 <= side_s9;
		if (adv[11])
			side_s11 <= side_s10;
	end

	// s12: mode select and output register
	logic [7:0] lum [3];
	pix_out_t   res_c;
	pix_out_t   out_s12;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (side_s11.vzero)
				lum[l] = side_s11.bytes[0];
			else if (side_s11.neg[l])
				lum[l] = 8'd0;
			else if (side_s11.ovf[l])
				lum[l] = 8'd255;
			else
				lum[l] = quo[l];
		end
		if (!color_q)
			res_c = '{blue_out: side_s11.bytes[0], green_out: 8'd0, red_out: 8'd0};
		else if (!luma_q)
			res_c = '{blue_out: side_s11.bytes[0], green_out: side_s11.bytes[1],
				red_out: side_s11.bytes[2]};
		else
			res_c = '{blue_out: lum[0], green_out: lum[1], red_out: lum[2]};
	end

	always_ff @(posedge clk) begin
		if (adv[12])
			out_s12 <= res_c;
	end

	assign dst_data = out_s12;

endmodule

>>> sv/cbg_checker.sv
module cbg_checker import cbg_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     src_valid,
	input logic     src_ready,
	input logic     dst_valid,
	input logic     dst_ready,
	input pix_out_t dst_data,
	input logic     cfg_valid,
	input logic     cfg_ready
);

	localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

	// Pixels accepted but not yet delivered
	logic [OCC_W-1:0] occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else
			occ_q <= occ_q + OCC_W'(src_valid && src_ready) - OCC_W'(dst_valid && dst_ready);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> occ_q != '0)
		else $error("result without a pending pixel");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_DEPTH))
		else $error("more pixels in flight than pipeline stages");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind contrast_brightness_gamma_pixel cbg_checker u_cbg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_ready (src_ready),
	.dst_valid (dst_valid),
	.dst_ready (dst_ready),
	.dst_data  (dst_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
